FILE: rtl/brl_pkg.sv
// brl_pkg: shared types and constants for the line rasterizer
// no dependencies; used by brl_stepper and bresenham_line_rasterizer_unit
package brl_pkg;

  localparam int COORD_BITS      = 12;
  localparam int WIDTH_BITS      = 13;
  localparam int ADDR_BITS       = 26;
  localparam int BYTE_BITS       = 8;
  localparam int ERR_BITS        = COORD_BITS + 4;
  localparam int BYTES_PER_PIXEL = 4;

  localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RESET = WIDTH_BITS'(640);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [BYTE_BITS-1:0]  paint_byte;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  byte_address;
    logic [BYTE_BITS-1:0]  pixel_byte;
    logic                  last;
  } out_item_t;

endpackage

FILE: rtl/brl_stepper.sv
// brl_stepper: line state registers, load setup and one bresenham step per cycle while fire is high
// depends on brl_pkg
module brl_stepper (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  input  brl_pkg::in_item_t                item,
  input  logic [brl_pkg::WIDTH_BITS-1:0]   frame_width,
  output logic                             emit,
  output brl_pkg::out_item_t               pixel
);

  localparam int CB = brl_pkg::COORD_BITS;
  localparam int EB = brl_pkg::ERR_BITS;
  localparam int AB = brl_pkg::ADDR_BITS;

  logic                   active;
  logic [CB-1:0]          major_pos;
  logic [CB-1:0]          major_end;
  logic [CB-1:0]          minor_pos;
  logic [CB-1:0]          major_delta;
  logic [CB:0]            minor_delta_twice;
  logic signed [EB-1:0]   error_acc;
  logic                   steep_flag;
  logic                   down_flag;
  logic [brl_pkg::BYTE_BITS-1:0] line_byte;

  // load setup
  logic [CB-1:0] dx, dy;
  logic          steep;
  logic [CB-1:0] a0, b0, a1, b1;
  logic          swap;
  logic [CB-1:0] ma, mi_s, me, mi_e;
  logic [CB-1:0] mdelta;
  logic [CB-1:0] nd;

  always_comb begin
    dx    = (item.start_x > item.end_x) ? item.start_x - item.end_x
                                        : item.end_x - item.start_x;
    dy    = (item.start_y > item.end_y) ? item.start_y - item.end_y
                                        : item.end_y - item.start_y;
    steep = dx < dy;
    a0    = steep ? item.start_y : item.start_x;
    b0    = steep ? item.start_x : item.start_y;
    a1    = steep ? item.end_y   : item.end_x;
    b1    = steep ? item.end_x   : item.end_y;
    swap  = a0 > a1;
    ma    = swap ? a1 : a0;
    mi_s  = swap ? b1 : b0;
    me    = swap ? a0 : a1;
    mi_e  = swap ? b0 : b1;
    mdelta = me - ma;
    nd    = (mi_s > mi_e) ? mi_s - mi_e : mi_e - mi_s;
  end

  // step
  logic [CB-1:0]        px, py;
  logic [AB-1:0]        lin;
  logic [CB-1:0]        major_next;
  logic                 is_last;
  logic signed [EB-1:0] err_sum;
  logic                 move;

  always_comb begin
    px         = steep_flag ? minor_pos : major_pos;
    py         = steep_flag ? major_pos : minor_pos;
    lin        = AB'(px) + AB'(AB'(py) * AB'(frame_width));
    major_next = major_pos + CB'(1);
    is_last    = major_next == major_end;
    err_sum    = error_acc + signed'(EB'(minor_delta_twice));
    move       = err_sum > signed'(EB'(major_delta));
    emit       = (item.operation == brl_pkg::OP_STEP) && active;
    pixel.pixel_x      = px;
    pixel.pixel_y      = py;
    pixel.byte_address = AB'(lin * AB'(brl_pkg::BYTES_PER_PIXEL));
    pixel.pixel_byte   = line_byte;
    pixel.last         = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (fire) begin
      if (item.operation == brl_pkg::OP_LOAD) begin
        active            <= mdelta != '0;
        major_pos         <= ma;
        major_end         <= me;
        minor_pos         <= mi_s;
        major_delta       <= mdelta;
        minor_delta_twice <= {nd, 1'b0};
        error_acc         <= '0;
        steep_flag        <= steep;
        down_flag         <= mi_e < mi_s;
        line_byte         <= item.paint_byte;
      end else if (active) begin
        major_pos <= major_next;
        if (move) begin
          minor_pos <= down_flag ? minor_pos - CB'(1) : minor_pos + CB'(1);
          error_acc <= err_sum - signed'(EB'({major_delta, 1'b0}));
        end else begin
          error_acc <= err_sum;
        end
        if (is_last) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/bresenham_line_rasterizer_unit.sv
// Line rasterizer: a load transaction sets up a line (no result), each step
// transaction after it returns one pixel with its frame byte address until the
// line ends; the end pixel is not drawn. One transaction is taken per clock unless
// item_stall holds it; a step is taken into the input register, then, once the
// result register is free, the combinational error update and address multiply
// load the result register, which raises result_valid. Sustained rate is one pixel
// per clock while result_stall stays low.
// depends on brl_pkg and brl_stepper
module bresenham_line_rasterizer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  brl_pkg::in_item_t              item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output brl_pkg::out_item_t             result,
  input  logic                           cfg_we,
  input  logic [brl_pkg::WIDTH_BITS-1:0] cfg_data
);

  logic [brl_pkg::WIDTH_BITS-1:0] frame_width;
  logic                           stage_valid;
  brl_pkg::in_item_t              stage_item;
  logic                           adv;
  logic                           fire;
  logic                           emit;
  brl_pkg::out_item_t             pixel;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = stage_valid && !adv;
  assign fire       = stage_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= brl_pkg::FRAME_WIDTH_RESET;
    end else if (cfg_we) begin
      frame_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  brl_stepper u_stepper (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (stage_item),
    .frame_width (frame_width),
    .emit        (emit),
    .pixel       (pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= pixel;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (stage_valid && result_valid && result_stall))
    else $error("input stalled while result register free");

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_valid && stage_item.operation == brl_pkg::OP_STEP))
    else $error("result without a step transaction");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (fire && stage_item.operation == brl_pkg::OP_LOAD) |=> !result_valid)
    else $error("load transaction produced a result");
`endif

endmodule

FILE: dv/bresenham_line_rasterizer_unit_tb.sv
// testbench for bresenham_line_rasterizer_unit: directed and random line loads and pixel
// steps, with each pixel checked against an in-bench line-stepping predictor
// depends on rtl/brl_pkg.sv and rtl/bresenham_line_rasterizer_unit.sv
`timescale 1ns / 100ps

module bresenham_line_rasterizer_unit_tb;

  localparam int CB = brl_pkg::COORD_BITS;
  localparam int WB = brl_pkg::WIDTH_BITS;
  localparam int AB = brl_pkg::ADDR_BITS;
  localparam int BB = brl_pkg::BYTE_BITS;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  brl_pkg::in_item_t     item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  brl_pkg::out_item_t    result;
  logic                  cfg_we       = 1'b0;
  logic [WB-1:0]         cfg_data     = '0;

  // line predictor state
  logic                  line_on;
  logic [CB-1:0]         maj_pos, maj_end, min_pos;
  int                    maj_delta, minor_twice, err_term;
  logic                  steep, heads_down;
  logic [BB-1:0]         line_color;
  logic [WB-1:0]         frame_w;

  brl_pkg::out_item_t pending_pixels[$];
  brl_pkg::out_item_t due_px;
  brl_pkg::in_item_t  cmd_q[$];
  int        items_left    = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        errors        = 0;
  logic      item_fired    = 1'b0;

  bresenham_line_rasterizer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int span(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic rasterize(input brl_pkg::in_item_t it);
    int                    sx, sy, ex, ey, t;
    brl_pkg::out_item_t    px;
    logic [CB-1:0]         nxt;
    longint unsigned       addr;
    if (it.operation == brl_pkg::OP_LOAD) begin
      sx = int'(it.start_x);
      sy = int'(it.start_y);
      ex = int'(it.end_x);
      ey = int'(it.end_y);
      steep = span(sx, ex) < span(sy, ey);
      if (steep) begin
        t = sx; sx = sy; sy = t;
        t = ex; ex = ey; ey = t;
      end
      if (sx > ex) begin
        t = sx; sx = ex; ex = t;
        t = sy; sy = ey; ey = t;
      end
      maj_pos     = CB'(sx);
      maj_end     = CB'(ex);
      min_pos     = CB'(sy);
      maj_delta   = ex - sx;
      heads_down  = ey < sy;
      minor_twice = 2 * span(sy, ey);
      err_term    = 0;
      line_color  = it.paint_byte;
      line_on     = maj_delta != 0;
    end else if (line_on) begin
      px.pixel_x      = steep ? min_pos : maj_pos;
      px.pixel_y      = steep ? maj_pos : min_pos;
      addr            = (longint'(px.pixel_x) + longint'(px.pixel_y) * longint'(frame_w))
                        * brl_pkg::BYTES_PER_PIXEL;
      px.byte_address = addr[AB-1:0];
      px.pixel_byte   = line_color;
      nxt             = maj_pos + CB'(1);
      px.last         = nxt == maj_end;
      pending_pixels.push_back(px);
      err_term += minor_twice;
      if (err_term > maj_delta) begin
        min_pos  = heads_down ? min_pos - CB'(1) : min_pos + CB'(1);
        err_term -= 2 * maj_delta;
      end
      maj_pos = nxt;
      if (px.last) line_on = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // prediction on accepted transactions, checking of accepted pixels
  always @(posedge clk) begin
    item_fired <= item_valid && !item_stall;
    if (rst) begin
      line_on     = 1'b0;
      maj_pos     = '0;
      maj_end     = '0;
      min_pos     = '0;
      maj_delta   = 0;
      minor_twice = 0;
      err_term    = 0;
      steep       = 1'b0;
      heads_down  = 1'b0;
      line_color  = '0;
      frame_w     = brl_pkg::FRAME_WIDTH_RESET;
    end else begin
      if (cfg_we) frame_w = cfg_data;
      if (item_valid && !item_stall) begin
        rasterize(item);
        items_left--;
      end
      if (result_valid && !result_stall) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d addr=%0h",
                   $time, result.pixel_x, result.pixel_y, result.byte_address);
          errors++;
        end else begin
          due_px = pending_pixels.pop_front();
          check_field("pixel_x", 32'(due_px.pixel_x), 32'(result.pixel_x));
          check_field("pixel_y", 32'(due_px.pixel_y), 32'(result.pixel_y));
          check_field("byte_address", 32'(due_px.byte_address), 32'(result.byte_address));
          check_field("pixel_byte", 32'(due_px.pixel_byte), 32'(result.pixel_byte));
          check_field("last", 32'(due_px.last), 32'(result.last));
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fired) begin
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item       <= cmd_q.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= $urandom_range(0, 99) < stall_pct;
  end

  task automatic push_item(input brl_pkg::in_item_t it);
    cmd_q.push_back(it);
    items_left++;
  endtask

  task automatic push_load(input int sx, input int sy, input int ex, input int ey,
                           input int color);
    brl_pkg::in_item_t it;
    it.operation  = brl_pkg::OP_LOAD;
    it.start_x    = CB'(sx);
    it.start_y    = CB'(sy);
    it.end_x      = CB'(ex);
    it.end_y      = CB'(ey);
    it.paint_byte = BB'(color);
    push_item(it);
  endtask

  task automatic push_noise(input logic op);
    logic [63:0]       bits;
    brl_pkg::in_item_t it;
    bits         = {$urandom(), $urandom()};
    it           = bits[$bits(brl_pkg::in_item_t)-1:0];
    it.operation = op;
    push_item(it);
  endtask

  task automatic push_steps(input int n);
    for (int i = 0; i < n; i++) push_noise(brl_pkg::OP_STEP);
  endtask

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r == 1) return (1 << CB) - 1;
    return $urandom_range(0, (1 << CB) - 1);
  endfunction

  function automatic int reach(input int from, input int offset);
    if (from + offset > (1 << CB) - 1 || (from >= offset && $urandom_range(0, 1) == 1))
      return from - offset;
    return from + offset;
  endfunction

  // mostly well-formed lines with random geometry, some noise, cut-short lines and lines stepped past their end
  task automatic random_line(output int used);
    int len, side, dx, dy, sx, sy, nsteps, r;
    if ($urandom_range(0, 99) < 12) begin
      push_noise(1'($urandom_range(0, 1)));
      used = 1;
      return;
    end
    len  = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
    side = ($urandom_range(0, 4) == 0) ? len : $urandom_range(0, len);
    if ($urandom_range(0, 1) == 1) begin
      dx = len; dy = side;
    end else begin
      dx = side; dy = len;
    end
    sx = pick_coord();
    sy = pick_coord();
    push_load(sx, sy, reach(sx, dx), reach(sy, dy), $urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r < 7) nsteps = len;
    else if (r < 9) nsteps = (len > 3) ? len - $urandom_range(1, 3) : 0;
    else nsteps = len + $urandom_range(1, 3);
    push_steps(nsteps);
    used = 1 + nsteps;
  endtask

  task automatic drain();
    while (items_left != 0 || pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_width(input int width);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= WB'(width);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(input int width, input int send_pct, input int hold_pct,
                           input int n);
    int done, used;
    drain();
    send_idle_pct = send_pct;
    stall_pct     = hold_pct;
    write_width(width);
    done = 0;
    while (done < n) begin
      random_line(used);
      done += used;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // step with no line loaded
    push_steps(1);
    // flat line, full color byte
    push_load(0, 0, 3, 0, 8'hff);
    push_steps(3);
    // reversed endpoints at the far corner
    push_load(4095, 4095, 4092, 4093, 8'h00);
    push_steps(3);
    // steep line running down, cut short by the next load
    push_load(5, 20, 7, 14, 8'ha5);
    push_steps(2);
    // single pixel line then a step past its end
    push_load(100, 100, 101, 100, 8'h5a);
    push_steps(2);
    // equal deltas
    push_load(0, 4095, 3, 4092, 8'h3c);
    push_steps(3);
    // no major extent
    push_load(7, 7, 7, 7, 8'h11);
    push_steps(1);
    // long diagonal replaced by an empty line
    push_load(0, 4095, 4095, 0, 8'h80);
    push_steps(2);
    push_load(4095, 0, 4095, 0, 8'hc3);
    push_steps(1);

    run_phase(1, 0, 0, 400);
    run_phase(4096, 79, 0, 400);
    run_phase((1 << WB) - 1, 0, 79, 400);
    // full-span line, cut short by the next load
    push_load(4095, 0, 0, 2000, 8'h96);
    push_steps(40);
    run_phase($urandom_range(1, 4096), 15, 15, 400);
    run_phase(0, 0, 0, 100);
    drain();

    if (errors == 0) begin
      $display("** bresenham_line_rasterizer_unit: PASSED **");
    end else begin
      $display("** bresenham_line_rasterizer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d transactions and %0d pixels outstanding",
             items_left, pending_pixels.size());
    $display("** bresenham_line_rasterizer_unit: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/brl_pkg.sv
rtl/brl_stepper.sv
rtl/bresenham_line_rasterizer_unit.sv
dv/bresenham_line_rasterizer_unit_tb.sv
